// ----- design/i2cmts_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master transaction sequencer package
// Shared item types, command codes and result-queue sizing.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_WDATA   = 2'd2;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_SEND    = 3'd2;
    localparam logic [2:0] CMD_RX_ACK  = 3'd3;
    localparam logic [2:0] CMD_RX_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;
    localparam logic [2:0] CMD_RESET   = 3'd6;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_PREAD  = 3'd2;
    localparam logic [2:0] OP_PWRITE = 3'd3;
    localparam logic [2:0] OP_PBOTH  = 3'd4;

    localparam logic [7:0] ST_START  = 8'h08;
    localparam logic [7:0] ST_RSTART = 8'h10;
    localparam logic [7:0] ST_WADDR  = 8'h18;
    localparam logic [7:0] ST_TXDATA = 8'h28;
    localparam logic [7:0] ST_RADDR  = 8'h40;
    localparam logic [7:0] ST_RXACK  = 8'h50;
    localparam logic [7:0] ST_RXNACK = 8'h58;
    localparam logic [7:0] ST_MASK   = 8'hF8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  op;
        logic [15:0] device_address;
        logic [7:0]  register_address;
        logic [15:0] byte_count;
        logic [7:0]  status_code;
        logic [7:0]  received_byte;
        logic [7:0]  write_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  command_byte;
        logic        need_data;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        finished;
        logic        success;
        logic [15:0] processed;
        logic        last;
    } out_item_t;

    // Up to four results from one input item.
    typedef struct packed {
        logic [2:0]      count;
        out_item_t [3:0] res;
    } burst_t;

    function automatic out_item_t mk(input logic [2:0] c, input logic [7:0] b);
        out_item_t o;
        o = '0;
        o.command = c;
        o.command_byte = b;
        return o;
    endfunction

endpackage

// ----- design/i2cmts_engine.sv -----
// ----------------------------------------------------------------------------
// I2C sequencer engine
// Transaction state machine: one input item per fire cycle into a result burst.
// ----------------------------------------------------------------------------
module i2cmts_engine
    import i2cmts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  in_item_t item,
    output burst_t   burst
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_WADDR_HI, PH_WADDR_LO, PH_REG, PH_NEED,
        PH_WDATA, PH_RESTART, PH_RDATA, PH_RADDR_HI, PH_RADDR_LO
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  oper_reg, oper_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  dreg_reg, dreg_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] done_reg, done_next;
    logic        sec_reg, sec_next;

    always_comb
    begin
        logic [7:0]  code;
        logic [15:0] a;
        logic        rd;
        logic [15:0] rem_dec;
        logic [15:0] done_inc;
        logic        ok;
        logic        fin;
        phase_next = phase_reg;
        oper_next  = oper_reg;
        addr_next  = addr_reg;
        dreg_next  = dreg_reg;
        rem_next   = rem_reg;
        done_next  = done_reg;
        sec_next   = sec_reg;
        burst      = '0;
        code       = item.status_code & ST_MASK;
        rem_dec    = rem_reg - 16'd1;
        done_inc   = done_reg + 16'd1;
        ok         = 1'b0;
        fin        = 1'b0;
        rd         = 1'b0;
        a          = '0;
        unique case (item.kind)
            KIND_REQUEST:
            begin
                if (phase_reg == PH_IDLE && item.op <= OP_PBOTH)
                begin
                    oper_next = item.op;
                    addr_next = {item.device_address[14:0], 1'b0};
                    dreg_next = item.register_address;
                    rem_next  = item.byte_count;
                    done_next = '0;
                    sec_next  = 1'b0;
                    burst.count = 3'd1;
                    if (item.op == OP_READ && item.byte_count == '0)
                    begin
                        burst.res[0] = mk(CMD_NONE, 8'h00);
                        burst.res[0].finished = 1'b1;
                        burst.res[0].success  = 1'b1;
                    end
                    else
                    begin
                        burst.res[0] = mk(CMD_START, 8'h00);
                        phase_next = PH_START;
                    end
                end
            end
            KIND_STATUS:
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (code != ST_START)
                            fin = 1'b1;
                        else
                        begin
                            rd = oper_reg == OP_PREAD || (oper_reg == OP_PBOTH && !sec_reg);
                            a = {addr_reg[15:1], rd};
                            burst.count = 3'd1;
                            if (a[15:12] == 4'hF)
                            begin
                                burst.res[0] = mk(CMD_SEND, a[15:8]);
                                phase_next = rd ? PH_RADDR_HI : PH_WADDR_HI;
                            end
                            else
                            begin
                                burst.res[0] = mk(CMD_SEND, a[7:0]);
                                phase_next = rd ? PH_RADDR_LO : PH_WADDR_LO;
                            end
                        end
                    end
                    PH_WADDR_HI, PH_RADDR_HI:
                    begin
                        rd = phase_reg == PH_RADDR_HI;
                        if (code != (rd ? ST_RADDR : ST_WADDR))
                            fin = 1'b1;
                        else
                        begin
                            burst.count = 3'd1;
                            burst.res[0] = mk(CMD_SEND, {addr_reg[7:1], rd});
                            phase_next = rd ? PH_RADDR_LO : PH_WADDR_LO;
                        end
                    end
                    PH_WADDR_LO:
                    begin
                        if (code != ST_WADDR)
                            fin = 1'b1;
                        else if (oper_reg <= OP_READ)
                        begin
                            burst.count = 3'd1;
                            burst.res[0] = mk(CMD_SEND, dreg_reg);
                            phase_next = PH_REG;
                        end
                        else
                        begin
                            fin = 1'b1;
                            ok  = 1'b1;
                        end
                    end
                    PH_RADDR_LO:
                    begin
                        if (code != ST_RADDR)
                            fin = 1'b1;
                        else if (oper_reg == OP_READ)
                        begin
                            burst.count = 3'd1;
                            burst.res[0] = mk(rem_reg > 16'd1 ? CMD_RX_ACK : CMD_RX_NACK, 8'h00);
                            phase_next = PH_RDATA;
                        end
                        else if (oper_reg == OP_PBOTH && !sec_reg)
                        begin
                            burst.count = 3'd3;
                            burst.res[0] = mk(CMD_STOP, 8'h00);
                            burst.res[1] = mk(CMD_RESET, 8'h00);
                            burst.res[2] = mk(CMD_START, 8'h00);
                            sec_next = 1'b1;
                            phase_next = PH_START;
                        end
                        else
                        begin
                            fin = 1'b1;
                            ok  = 1'b1;
                        end
                    end
                    PH_REG:
                    begin
                        if (code != ST_TXDATA)
                            fin = 1'b1;
                        else if (oper_reg == OP_READ)
                        begin
                            burst.count = 3'd1;
                            burst.res[0] = mk(CMD_START, 8'h00);
                            phase_next = PH_RESTART;
                        end
                        else if (rem_reg == '0)
                        begin
                            fin = 1'b1;
                            ok  = 1'b1;
                        end
                        else
                        begin
                            burst.count = 3'd1;
                            burst.res[0] = mk(CMD_NONE, 8'h00);
                            burst.res[0].need_data = 1'b1;
                            phase_next = PH_NEED;
                        end
                    end
                    PH_WDATA:
                    begin
                        if (code != ST_TXDATA)
                            fin = 1'b1;
                        else
                        begin
                            done_next = done_inc;
                            rem_next  = rem_dec;
                            if (rem_dec == '0)
                            begin
                                fin = 1'b1;
                                ok  = 1'b1;
                            end
                            else
                            begin
                                burst.count = 3'd1;
                                burst.res[0] = mk(CMD_NONE, 8'h00);
                                burst.res[0].need_data = 1'b1;
                                phase_next = PH_NEED;
                            end
                        end
                    end
                    PH_RESTART:
                    begin
                        if (code != ST_RSTART)
                            fin = 1'b1;
                        else
                        begin
                            a = {addr_reg[15:1], 1'b1};
                            burst.count = 3'd1;
                            if (a[15:12] == 4'hF)
                            begin
                                burst.res[0] = mk(CMD_SEND, a[15:8]);
                                phase_next = PH_RADDR_HI;
                            end
                            else
                            begin
                                burst.res[0] = mk(CMD_SEND, a[7:0]);
                                phase_next = PH_RADDR_LO;
                            end
                        end
                    end
                    PH_RDATA:
                    begin
                        if (code != (rem_reg > 16'd1 ? ST_RXACK : ST_RXNACK))
                            fin = 1'b1;
                        else
                        begin
                            burst.count = 3'd2;
                            burst.res[0] = mk(CMD_NONE, 8'h00);
                            burst.res[0].read_valid = 1'b1;
                            burst.res[0].read_data  = item.received_byte;
                            done_next = done_inc;
                            rem_next  = rem_dec;
                            if (rem_dec == '0)
                            begin
                                // Data result, then stop and reset.
                                burst.count = 3'd3;
                                burst.res[1] = mk(CMD_STOP, 8'h00);
                                burst.res[2] = mk(CMD_RESET, 8'h00);
                                burst.res[2].finished  = 1'b1;
                                burst.res[2].success   = 1'b1;
                                burst.res[2].processed = done_inc;
                                phase_next = PH_IDLE;
                                sec_next   = 1'b0;
                            end
                            else
                                burst.res[1] = mk(rem_dec > 16'd1 ? CMD_RX_ACK : CMD_RX_NACK,
                                                  8'h00);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (fin)
                begin
                    burst.count = 3'd2;
                    burst.res[0] = mk(CMD_STOP, 8'h00);
                    burst.res[1] = mk(CMD_RESET, 8'h00);
                    burst.res[1].finished  = 1'b1;
                    burst.res[1].success   = ok;
                    burst.res[1].processed = done_next;
                    phase_next = PH_IDLE;
                    sec_next   = 1'b0;
                end
            end
            KIND_WDATA:
            begin
                if (phase_reg == PH_NEED)
                begin
                    burst.count = 3'd1;
                    burst.res[0] = mk(CMD_SEND, item.write_byte);
                    phase_next = PH_WDATA;
                end
            end
            default:
            begin
            end
        endcase
        if (!fire)
            burst.count = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            oper_reg  <= '0;
            addr_reg  <= '0;
            dreg_reg  <= '0;
            rem_reg   <= '0;
            done_reg  <= '0;
            sec_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            oper_reg  <= oper_next;
            addr_reg  <= addr_next;
            dreg_reg  <= dreg_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
            sec_reg   <= sec_next;
        end
    end

endmodule

// ----- design/i2cmts_queue.sv -----
// ----------------------------------------------------------------------------
// I2C sequencer result queue
// Takes a burst of up to four results per cycle, gives one per pop.
// ----------------------------------------------------------------------------
module i2cmts_queue
    import i2cmts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  burst_t    burst,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output out_item_t head
);

    out_item_t      mem [QDEPTH];
    out_item_t      wr_item [4];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           do_pop;

    assign empty  = cnt_reg == '0;
    // Room for a whole burst must exist before an item is taken.
    assign full   = cnt_reg > (QAW+1)'(QDEPTH - 4);
    assign do_pop = pop && !empty;
    assign head   = mem[rp_reg];

    // The final result of a burst carries the last mark.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            wr_item[i]      = burst.res[i];
            wr_item[i].last = (3'(i + 1) == burst.count);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < burst.count)
                mem[wp_reg + QAW'(i)] <= wr_item[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + QAW'(burst.count);
            rp_reg  <= rp_reg + QAW'(do_pop);
            cnt_reg <= cnt_reg + (QAW+1)'(burst.count) - (QAW+1)'(do_pop);
        end
    end

endmodule

// ----- design/i2c_master_transaction_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// Turns requests, bus engine status items and write data into engine commands.
// ----------------------------------------------------------------------------
// Each accepted item is decoded by the front state machine in the cycle it is
// accepted, producing up to three result items that are written at once into an
// eight-entry result queue. An item can be accepted every cycle; full rises
// only while fewer than four queue entries are free, so the rate is one item
// per cycle while full is low; multi-result bursts can fill the queue even
// while results are popped. Results enter the queue in order and leave at one
// per pop.
module i2c_master_transaction_sequencer
    import i2cmts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    burst_t burst;
    logic   fire;

    assign fire = push && !full;

    i2cmts_engine u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item),
        .burst (burst)
    );

    i2cmts_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .burst (burst),
        .pop   (pop),
        .full  (full),
        .empty (empty),
        .head  (out_item)
    );

endmodule

// ----- design/i2cmts_checker.sv -----
// ----------------------------------------------------------------------------
// I2C sequencer port checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmts_checker
    import i2cmts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);

    // A finished result always carries the last mark of its item.
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.finished |-> out_item.last)
        else $error("finished result without last");

    // A held head does not change until popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("queue head changed without pop");

    // With nothing queued the block is never full.
    a_nofull: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !full)
        else $error("full while empty");

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
